// ===== rtl/bsfb_pkg.sv =====
package bsfb_pkg;

  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] ESC_FLAG     = 8'h5E;
  localparam logic [7:0] ESC_ESC      = 8'h5D;
  localparam logic [7:0] CTRL_ONE     = 8'h40;
  localparam logic [7:0] CTRL_ZERO    = 8'h00;
  localparam logic [7:0] ADDRESS_INIT = 8'h03;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_start;
    logic       frame_end;
    logic       sequence_bit;
  } payload_item_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_done;
  } line_item_t;

  // Position within the output bytes that one payload item causes.
  typedef enum logic [3:0] {
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_BCC1,
    PH_DATA,
    PH_DATA_ESC,
    PH_BCC2,
    PH_BCC2_ESC,
    PH_CLOSE
  } phase_t;

endpackage

// ===== rtl/byte_stuffing_frame_builder_top.sv =====
// Byte-stuffing frame builder. Payload items go in on the payload channel and
// the framed line stream comes out on the line channel, one byte per item
// there, at one line byte per clock cycle while the line side is ready. An
// item marked frame_start first sends the header (flag 0x7E, the address
// register, control 0x00 or 0x40 by sequence_bit, and BCC1 = address XOR
// control, none of them stuffed) and clears the running check. Every payload
// byte goes into the running XOR check and is sent stuffed (0x7E as 7D 5E,
// 0x7D as 7D 5D). An item marked frame_end then sends the stuffed BCC2 and a
// closing flag, which carries frame_done. run_last marks the final line byte
// of each payload item. An item causes one or two line bytes for a plain byte,
// up to nine for a one-byte frame with escapes, so a stream of payload bytes
// with no escapes runs at one item per cycle while the line side is ready, and
// each escape adds a line byte. The pace is set by the single line output
// register, which takes one byte per cycle while empty or drained. The next
// payload item is taken in the same cycle in which the last line byte of the
// current one is produced, so no cycle is lost between items. The address
// register resets to 0x03 and should be written only while the block is idle.
module byte_stuffing_frame_builder_top
  import bsfb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          payload_valid,
  output logic          payload_ready,
  input  payload_item_t payload,
  output logic          line_valid,
  input  logic          line_ready,
  output line_item_t    line,
  input  logic          cfg_write_enable,
  input  logic [7:0]    cfg_write_data
);

  logic [7:0]    address;
  logic [7:0]    check;
  logic [7:0]    check_next;
  payload_item_t cur;
  logic          cur_valid;
  phase_t        phase;
  phase_t        phase_next;
  phase_t        phase_after;
  logic          advance;
  logic          item_last;
  logic [7:0]    ctrl;
  logic [7:0]    data_check;
  logic          data_esc;
  logic          check_esc;
  line_item_t    emit;

  // The line register can take a byte when it is empty or being drained.
  assign advance       = cur_valid && (!line_valid || line_ready);
  assign payload_ready = !cur_valid || (advance && item_last);

  assign ctrl       = cur.sequence_bit ? CTRL_ONE : CTRL_ZERO;
  // The check including the held byte; a start item begins from zero.
  assign data_check = (cur.frame_start ? 8'h00 : check) ^ cur.payload_byte;
  assign data_esc   = (cur.payload_byte == FLAG_BYTE) || (cur.payload_byte == ESC_BYTE);
  assign check_esc  = (data_check == FLAG_BYTE) || (data_check == ESC_BYTE);
  assign check_next = cur.frame_end ? 8'h00 : data_check;

  // Next phase within the held item.
  always_comb begin
    phase_after = PH_CLOSE;
    item_last   = 1'b0;
    unique case (phase)
      PH_FLAG: begin
        phase_after = PH_ADDR;
      end
      PH_ADDR: begin
        phase_after = PH_CTRL;
      end
      PH_CTRL: begin
        phase_after = PH_BCC1;
      end
      PH_BCC1: begin
        phase_after = PH_DATA;
      end
      PH_DATA: begin
        if (data_esc) begin
          phase_after = PH_DATA_ESC;
        end else if (cur.frame_end) begin
          phase_after = PH_BCC2;
        end else begin
          item_last = 1'b1;
        end
      end
      PH_DATA_ESC: begin
        if (cur.frame_end) begin
          phase_after = PH_BCC2;
        end else begin
          item_last = 1'b1;
        end
      end
      PH_BCC2: begin
        phase_after = check_esc ? PH_BCC2_ESC : PH_CLOSE;
      end
      PH_BCC2_ESC: begin
        phase_after = PH_CLOSE;
      end
      PH_CLOSE: begin
        item_last = 1'b1;
      end
      default: begin
        item_last = 1'b1;
      end
    endcase
  end

  // Phase register update, including the first phase of a freshly taken item.
  always_comb begin
    phase_next = phase;
    if (payload_valid && payload_ready) begin
      phase_next = payload.frame_start ? PH_FLAG : PH_DATA;
    end else if (advance) begin
      phase_next = phase_after;
    end
  end

  // Line byte for the current phase.
  always_comb begin
    emit.line_byte  = FLAG_BYTE;
    emit.run_last   = item_last;
    emit.frame_done = 1'b0;
    unique case (phase)
      PH_FLAG:     emit.line_byte = FLAG_BYTE;
      PH_ADDR:     emit.line_byte = address;
      PH_CTRL:     emit.line_byte = ctrl;
      PH_BCC1:     emit.line_byte = address ^ ctrl;
      PH_DATA:     emit.line_byte = data_esc ? ESC_BYTE : cur.payload_byte;
      PH_DATA_ESC: emit.line_byte = (cur.payload_byte == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
      PH_BCC2:     emit.line_byte = check_esc ? ESC_BYTE : data_check;
      PH_BCC2_ESC: emit.line_byte = (data_check == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
      PH_CLOSE: begin
        emit.line_byte  = FLAG_BYTE;
        emit.frame_done = 1'b1;
      end
      default:     emit.line_byte = FLAG_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address    <= ADDRESS_INIT;
      check      <= 8'h00;
      cur_valid  <= 1'b0;
      phase      <= PH_DATA;
      line_valid <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        address <= cfg_write_data;
      end
      phase <= phase_next;
      if (advance && item_last) begin
        check <= check_next;
      end
      if (payload_ready) begin
        cur_valid <= payload_valid;
      end
      if (advance) begin
        line_valid <= 1'b1;
      end else if (line_ready) begin
        line_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (payload_valid && payload_ready) begin
      cur <= payload;
    end
    if (advance) begin
      line <= emit;
    end
  end

endmodule
